@@ hdl/fhm_pkg.sv @@
// Shared types and constants of the fan health monitor.
`timescale 1ns / 1ps

package fhm_pkg;

  // Consecutive fan-fault polls before a hardware fault is declared.
  localparam logic [1:0] FaultPolls = 2'd3;

  // Number of bits in the margin multiplier (one shift-add step per bit).
  localparam int unsigned MarginW = 8;
  localparam int unsigned SpeedW  = 16;
  localparam int unsigned ProdW   = SpeedW + MarginW;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMargin    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegLim  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegIntegUp   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntegDown = 3'd3;
  localparam logic [CfgIdxW-1:0] RegReqSpeed  = 3'd4;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_COMM = 2'd1,
    KIND_HW   = 2'd2,
    KIND_CFG  = 2'd3
  } fault_kind_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL   = 5'b00100,
    S_CMP   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  // One poll, as captured from the input beat.
  typedef struct packed {
    logic              speed_write_error;
    logic [SpeedW-1:0] measured_speed;
    logic              speed_read_error;
    logic              fan_fault;
    logic              status_read_error;
    logic [SpeedW-1:0] info_max_speed;
    logic              info_read_error;
    logic              info_refresh;
  } poll_t;

  // One result; packed so oper_fault lands in the lowest bit.
  typedef struct packed {
    logic              speed_error;
    logic [SpeedW-1:0] write_speed;
    logic              speed_write;
    logic              info_failed;
    logic              status_changed;
    fault_kind_e       fault_kind;
    logic              oper_fault;
  } result_t;

endpackage

@@ hdl/fan_health_monitor.sv @@
// Fan health monitor: per-poll fault qualification and speed tracking.
`timescale 1ns / 1ps

// Channel   | Dir | Signals                                  | Beat
// ----------+-----+------------------------------------------+----------------------------
// poll in   | in  | s_axis_tvalid/tready/tdata[39:0]         | one fan poll
// result    | out | m_axis_tvalid/tready/tdata[23:0]         | one result per poll
// config    | in  | cfg_valid/ready, cfg_index[2:0], cfg_data | one register write
//
// A poll that ends on a fault or abort goes from check straight to output; when
// the speed check runs, the 8-step shift-add margin multiply and compare follow.
// The multiply forms margin_percent * target so that the percent test
// 100*diff/target >= margin becomes 100*diff >= margin*target, no divider.
// Reset clears all state and loads the register defaults; no clearing pass.
// A stalled result holds in the output register; the next poll is taken
// meanwhile and waits in its final state until the output register frees.
// Config writes are taken only while idle (cfg_ready_o follows s_axis_tready_o).

module fan_health_monitor
  import fhm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // [0] info_refresh, [1] info_read_error, [17:2] info_max_speed,
  // [18] status_read_error, [19] fan_fault, [20] speed_read_error,
  // [36:21] measured_speed, [37] speed_write_error, [39:38] zero
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [39:0]        s_axis_tdata_i,
  // [0] oper_fault, [2:1] fault_kind, [3] status_changed, [4] info_failed,
  // [5] speed_write, [21:6] write_speed, [22] speed_error, [23] zero
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [23:0]        m_axis_tdata_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SpeedW-1:0]  cfg_data_i
);

  // Configuration registers
  logic [MarginW-1:0] margin_q;
  logic [SpeedW-1:0]  integ_lim_q, integ_up_q, integ_down_q;

  // Block state
  logic              info_valid_q;
  logic [SpeedW-1:0] max_speed_q;
  logic [1:0]        fault_cnt_q;
  logic [SpeedW-1:0] cmd_speed_q;
  logic [SpeedW-1:0] integ_q;
  logic              spd_err_q;
  logic              prev_fault_q;

  // Sequencer and datapath
  state_e             state_q;
  poll_t              poll_q;
  logic [SpeedW-1:0]  target_q;
  logic [SpeedW-1:0]  diff_q;
  logic [ProdW-1:0]   acc_q;       // margin * target accumulator
  logic [ProdW-1:0]   mcand_q;     // target, shifted left each step
  logic [MarginW-1:0] mplier_q;    // margin, shifted right each step
  logic [2:0]         step_q;
  logic [ProdW-1:0]   prod100_q;   // 100 * diff
  result_t            res_q;
  result_t            out_q;
  logic               out_valid_q;

  logic in_fire, out_free, cfg_fire;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

  // ---- check stage: info latch, early faults, target ----
  logic              need_info, abort, chk_fail;
  logic [SpeedW-1:0] max_eff, target_c;
  logic [1:0]        fc_inc;
  fault_kind_e       chk_kind;
  result_t           chk_res;
  always_comb begin
    need_info = !info_valid_q || poll_q.info_refresh;
    abort     = need_info && poll_q.info_read_error;
    max_eff   = need_info ? poll_q.info_max_speed : max_speed_q;
    target_c  = (cmd_speed_q == '0) ? max_eff : cmd_speed_q;
    fc_inc    = (fault_cnt_q < FaultPolls) ? fault_cnt_q + 2'd1 : fault_cnt_q;
    chk_fail  = 1'b0;
    chk_kind  = KIND_NONE;
    if (poll_q.status_read_error) begin
      chk_fail = 1'b1;
      chk_kind = KIND_COMM;
    end else if (poll_q.fan_fault) begin
      // fault only once it has persisted long enough
      chk_fail = (fc_inc >= FaultPolls);
      chk_kind = chk_fail ? KIND_HW : KIND_NONE;
    end else if (poll_q.speed_read_error) begin
      chk_fail = 1'b1;
      chk_kind = KIND_COMM;
    end else if (target_c == '0) begin
      chk_fail = 1'b1;
      chk_kind = KIND_CFG;
    end
    chk_res             = '0;
    chk_res.speed_error = spd_err_q;
    if (abort) begin
      chk_res.info_failed = 1'b1;
    end else begin
      chk_res.oper_fault     = chk_fail;
      chk_res.fault_kind     = chk_kind;
      chk_res.status_changed = (chk_fail != prev_fault_q);
    end
  end

  // ---- compare stage: margin test and leaky integrator ----
  logic              out_margin, wr, comm, flag_n;
  logic [SpeedW:0]   integ_sum;
  logic [SpeedW-1:0] integ_n;
  result_t           cmp_res;
  always_comb begin
    out_margin = prod100_q >= acc_q;
    wr         = out_margin && (cmd_speed_q != target_q);
    comm       = wr && poll_q.speed_write_error;
    integ_sum  = {1'b0, integ_q} + {1'b0, integ_up_q};
    integ_n    = integ_q;
    flag_n     = spd_err_q;
    if (out_margin) begin
      if (integ_q < integ_lim_q) begin
        if (integ_sum >= {1'b0, integ_lim_q}) begin
          integ_n = integ_lim_q;
          flag_n  = 1'b1;
        end else begin
          integ_n = integ_sum[SpeedW-1:0];
        end
      end
    end else begin
      integ_n = (integ_down_q > integ_q) ? '0 : integ_q - integ_down_q;
      if (integ_n == '0) begin
        flag_n = 1'b0;
      end
    end
    cmp_res                = '0;
    cmp_res.speed_write    = wr;
    cmp_res.write_speed    = wr ? target_q : '0;
    cmp_res.speed_error    = flag_n;
    cmp_res.oper_fault     = flag_n || comm;
    cmp_res.fault_kind     = flag_n ? KIND_HW : (comm ? KIND_COMM : KIND_NONE);
    cmp_res.status_changed = (flag_n || comm) != prev_fault_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      margin_q     <= 8'd10;
      integ_lim_q  <= 16'd8;
      integ_up_q   <= 16'd2;
      integ_down_q <= 16'd1;
      info_valid_q <= 1'b0;
      max_speed_q  <= '0;
      fault_cnt_q  <= '0;
      cmd_speed_q  <= '0;
      integ_q      <= '0;
      spd_err_q    <= 1'b0;
      prev_fault_q <= 1'b0;
      poll_q       <= '0;
      target_q     <= '0;
      diff_q       <= '0;
      acc_q        <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      step_q       <= '0;
      prod100_q    <= '0;
      res_q        <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            poll_q  <= poll_t'(s_axis_tdata_i[$bits(poll_t)-1:0]);
            state_q <= S_CHECK;
          end
        end

        S_CHECK: begin
          res_q <= chk_res;
          if (abort) begin
            prev_fault_q <= 1'b0;
            state_q      <= S_OUT;
          end else begin
            if (need_info) begin
              max_speed_q  <= poll_q.info_max_speed;
              info_valid_q <= 1'b1;
            end
            if (poll_q.status_read_error) begin
              prev_fault_q <= chk_fail;
              state_q      <= S_OUT;
            end else if (poll_q.fan_fault) begin
              fault_cnt_q  <= fc_inc;
              prev_fault_q <= chk_fail;
              state_q      <= S_OUT;
            end else begin
              fault_cnt_q <= '0;
              if (poll_q.speed_read_error || (target_c == '0)) begin
                prev_fault_q <= chk_fail;
                state_q      <= S_OUT;
              end else begin
                target_q <= target_c;
                diff_q   <= (poll_q.measured_speed >= target_c)
                            ? poll_q.measured_speed - target_c
                            : target_c - poll_q.measured_speed;
                acc_q    <= '0;
                mcand_q  <= {{MarginW{1'b0}}, target_c};
                mplier_q <= margin_q;
                step_q   <= '0;
                state_q  <= S_MUL;
              end
            end
          end
        end

        S_MUL: begin
          // one shift-add step per cycle
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q   <= {mcand_q[ProdW-2:0], 1'b0};
          mplier_q  <= {1'b0, mplier_q[MarginW-1:1]};
          step_q    <= step_q + 3'd1;
          prod100_q <= {2'b00, diff_q, 6'b0} + {3'b000, diff_q, 5'b0}
                     + {6'b0, diff_q, 2'b0};
          if (step_q == 3'(MarginW - 1)) begin
            state_q <= S_CMP;
          end
        end

        S_CMP: begin
          integ_q   <= integ_n;
          spd_err_q <= flag_n;
          if (wr && !poll_q.speed_write_error) begin
            cmd_speed_q <= target_q;
          end
          res_q        <= cmp_res;
          prev_fault_q <= flag_n || comm;
          state_q      <= S_OUT;
        end

        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase

      // config writes land only while idle, so they never meet a poll update
      if (cfg_fire) begin
        case (cfg_index_i)
          RegMargin:    margin_q     <= cfg_data_i[MarginW-1:0];
          RegIntegLim:  integ_lim_q  <= cfg_data_i;
          RegIntegUp:   integ_up_q   <= cfg_data_i;
          RegIntegDown: integ_down_q <= cfg_data_i;
          RegReqSpeed:  cmd_speed_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Output register: loads from the final state, drains on tready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_q       <= res_q;
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // ---- assertions ----
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_flag_needs_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spd_err_q |-> (integ_q != '0))
    else $error("speed error set with empty integrator");

  a_abort_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[4]) |-> (m_axis_tdata_o[3:0] == 4'b0000
      && !m_axis_tdata_o[5]))
    else $error("aborted poll reports a fault or write");

  a_fault_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && fault_cnt_q == FaultPolls) |=> (fault_cnt_q == FaultPolls
      || fault_cnt_q == 2'd0))
    else $error("fault count left saturation other than by clearing");

endmodule

@@ tb/fhm_poll_checker.sv @@
// Poll checker: predicts each result of the fan health monitor and compares it.
`timescale 1ns / 1ps

module fhm_poll_checker
  import fhm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [39:0]        s_tdata_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [23:0]        m_tdata_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SpeedW-1:0]  cfg_data_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);

  localparam int unsigned MaxShown = 10;

  // register copies
  logic [MarginW-1:0] margin_pct_q;
  logic [SpeedW-1:0]  integ_limit_q;
  logic [SpeedW-1:0]  integ_up_q;
  logic [SpeedW-1:0]  integ_down_q;

  // poll state
  logic               max_known_q;
  logic [SpeedW-1:0]  max_rpm_q;
  logic [1:0]         fault_run_q;
  logic [SpeedW-1:0]  cmd_rpm_q;
  logic [SpeedW-1:0]  integ_q;
  logic               spd_flag_q;
  logic               last_fail_q;

  result_t     predicted_q[$];
  result_t     want;
  result_t     got;
  int unsigned mismatches;
  int unsigned checked;

  function automatic fault_kind_e worst_kind(input fault_kind_e a, input fault_kind_e b);
    return (b > a) ? b : a;
  endfunction

  task automatic load_defaults();
    margin_pct_q  = 8'd10;
    integ_limit_q = 16'd8;
    integ_up_q    = 16'd2;
    integ_down_q  = 16'd1;
    max_known_q   = 1'b0;
    max_rpm_q     = '0;
    fault_run_q   = '0;
    cmd_rpm_q     = '0;
    integ_q       = '0;
    spd_flag_q    = 1'b0;
    last_fail_q   = 1'b0;
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [SpeedW-1:0] val);
    case (idx)
      RegMargin:    margin_pct_q  = val[MarginW-1:0];
      RegIntegLim:  integ_limit_q = val;
      RegIntegUp:   integ_up_q    = val;
      RegIntegDown: integ_down_q  = val;
      RegReqSpeed:  cmd_rpm_q     = val;  // loads the commanded speed too
      default: ;
    endcase
  endtask

  // One poll: updates the state and returns the result it produces.
  task automatic predict_poll(input poll_t p, output result_t r);
    logic              fail;
    fault_kind_e       kind;
    logic [SpeedW-1:0] target;
    logic [SpeedW:0]   integ_sum;
    int unsigned       meas;
    int unsigned       diff;
    int unsigned       pct;
    r    = '0;
    fail = 1'b0;
    kind = KIND_NONE;
    if (!max_known_q || p.info_refresh) begin
      if (p.info_read_error) begin
        // aborted poll: only the previous status is touched
        last_fail_q   = 1'b0;
        r.info_failed = 1'b1;
        r.speed_error = spd_flag_q;
        return;
      end
      max_rpm_q   = p.info_max_speed;
      max_known_q = 1'b1;
    end
    if (p.status_read_error) begin
      fail = 1'b1;
      kind = worst_kind(kind, KIND_COMM);
    end else if (p.fan_fault) begin
      if (fault_run_q < FaultPolls) fault_run_q = fault_run_q + 2'd1;
      if (fault_run_q >= FaultPolls) begin
        fail = 1'b1;
        kind = worst_kind(kind, KIND_HW);
      end
    end else begin
      fault_run_q = '0;
      target = (cmd_rpm_q == '0) ? max_rpm_q : cmd_rpm_q;
      if (p.speed_read_error) begin
        fail = 1'b1;
        kind = worst_kind(kind, KIND_COMM);
      end else if (target == '0) begin
        fail = 1'b1;
        kind = worst_kind(kind, KIND_CFG);
      end else begin
        meas = p.measured_speed;
        diff = (meas >= target) ? meas - target : target - meas;
        pct  = (100 * diff) / target;
        if (pct >= margin_pct_q) begin
          if (cmd_rpm_q != target) begin
            r.speed_write = 1'b1;
            r.write_speed = target;
            if (p.speed_write_error) begin
              fail = 1'b1;
              kind = worst_kind(kind, KIND_COMM);
            end else begin
              cmd_rpm_q = target;
            end
          end
          if (integ_q < integ_limit_q) begin
            integ_sum = {1'b0, integ_q} + {1'b0, integ_up_q};
            if (integ_sum >= {1'b0, integ_limit_q}) begin
              spd_flag_q = 1'b1;
              integ_q    = integ_limit_q;
            end else begin
              integ_q = integ_sum[SpeedW-1:0];
            end
          end
        end else begin
          integ_q = (integ_down_q > integ_q) ? '0 : integ_q - integ_down_q;
          if (integ_q == '0) spd_flag_q = 1'b0;
        end
        if (spd_flag_q) begin
          fail = 1'b1;
          kind = worst_kind(kind, KIND_HW);
        end
      end
    end
    r.status_changed = (fail != last_fail_q);
    last_fail_q      = fail;
    r.oper_fault     = fail;
    r.fault_kind     = kind;
    r.speed_error    = spd_flag_q;
  endtask

  task automatic compare_field(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= MaxShown)
        $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                 $time, checked, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_defaults();
      predicted_q.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[$bits(result_t)-1:0];
        if (predicted_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown)
            $display("%0t: result 0x%0h with no poll waiting", $time, m_tdata_i);
        end else begin
          want = predicted_q.pop_front();
          compare_field("oper_fault", want.oper_fault, got.oper_fault);
          compare_field("fault_kind", want.fault_kind, got.fault_kind);
          compare_field("status_changed", want.status_changed, got.status_changed);
          compare_field("info_failed", want.info_failed, got.info_failed);
          compare_field("speed_write", want.speed_write, got.speed_write);
          compare_field("write_speed", want.write_speed, got.write_speed);
          compare_field("speed_error", want.speed_error, got.speed_error);
          compare_field("pad bit", 0, m_tdata_i[23]);
        end
        checked++;
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (s_tvalid_i && s_tready_i) begin
        predict_poll(s_tdata_i[$bits(poll_t)-1:0], want);
        predicted_q.push_back(want);
      end
    end
    mismatches_o <= mismatches;
    checked_o    <= checked;
    pending_o    <= predicted_q.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: poll and register stimulus, result-side flow control, verdict.
`timescale 1ns / 1ps

// Flow of the run:
//  - reset, then a directed block of polls walking through aborts, faults,
//    fault qualification, speed writes, integrator saturation and clearing,
//    with register writes between groups (all registers, extremes included)
//  - random phases: each one drains, picks a nominal fan speed, writes a random
//    subset of registers, then sends mostly plausible polls around that speed
//  - the result side stalls at random; twice it holds off for a long stretch
//    while polls keep coming, so the block backs up onto its input
//  - the checker beside the DUT predicts every result and counts mismatches
module tb;
  import fhm_pkg::*;

  localparam int unsigned NumRegs      = 2 ** CfgIdxW;
  localparam int unsigned RandomPolls  = 750;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned TailCycles   = 50;
  localparam int unsigned CycleLimit   = 600_000;

  logic               clk_i = 1'b0;
  logic               rst_n = 1'b0;

  logic               s_tvalid  = 1'b0;
  logic [39:0]        s_tdata   = '0;
  logic               m_tready  = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [SpeedW-1:0]  cfg_data  = '0;

  logic               s_axis_tready_o;
  logic               m_axis_tvalid_o;
  logic [23:0]        m_axis_tdata_o;
  logic               cfg_ready_o;

  int unsigned        mismatches;
  int unsigned        pending;
  int unsigned        checked;

  // stimulus bookkeeping
  int unsigned        polls_sent  = 0;
  int unsigned        cfg_writes  = 0;
  int unsigned        cycle_cnt   = 0;
  int unsigned        fault_burst = 0;
  int                 nominal_rpm = 1000;
  bit                 idle_on     = 1'b1;
  int unsigned        holds_asked = 0;
  int unsigned        holds_done  = 0;
  logic [SpeedW-1:0]  cfg_shadow [NumRegs];

  fan_health_monitor u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  fhm_poll_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_axis_tdata_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: ends a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("** fan_health_monitor: FAILED **");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones; none while idle_on is clear.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [NumRegs-1:0] reg_bit(input int idx);
    return NumRegs'(1) << idx;
  endfunction

  function automatic poll_t mk_poll(input bit refresh, input bit info_err,
                                    input logic [SpeedW-1:0] info_max, input bit status_err,
                                    input bit fan_fault, input bit spd_rd_err,
                                    input logic [SpeedW-1:0] meas, input bit write_err);
    poll_t p;
    p.info_refresh      = refresh;
    p.info_read_error   = info_err;
    p.info_max_speed    = info_max;
    p.status_read_error = status_err;
    p.fan_fault         = fan_fault;
    p.speed_read_error  = spd_rd_err;
    p.measured_speed    = meas;
    p.speed_write_error = write_err;
    return p;
  endfunction

  // Plausible poll around nominal_rpm; fan faults come in runs so that
  // the three-poll qualification is reached and also broken off.
  function automatic poll_t random_poll();
    poll_t p;
    int    dev;
    int    meas;
    int    span;
    p.info_refresh      = ($urandom_range(0, 9) == 0);
    p.info_read_error   = ($urandom_range(0, 24) == 0);
    p.info_max_speed    = ($urandom_range(0, 9) == 0) ? SpeedW'($urandom)
                                                      : SpeedW'(nominal_rpm);
    p.status_read_error = ($urandom_range(0, 29) == 0);
    p.fan_fault         = 1'b0;
    if (fault_burst != 0) begin
      p.fan_fault = 1'b1;
      fault_burst--;
    end else if ($urandom_range(0, 19) == 0) begin
      fault_burst = $urandom_range(1, 5);
    end
    p.speed_read_error  = ($urandom_range(0, 29) == 0);
    p.speed_write_error = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 9))
      0: meas = $urandom_range(0, 65535);
      1: meas = 0;
      default: begin
        // deviation spread over roughly twice the margin
        span = 2 * int'(cfg_shadow[RegMargin][MarginW-1:0]) + 4;
        dev  = nominal_rpm * int'($urandom_range(0, span)) / 100;
        meas = ($urandom_range(0, 1) == 0) ? nominal_rpm + dev : nominal_rpm - dev;
      end
    endcase
    if (meas < 0) meas = 0;
    if (meas > 65535) meas = 65535;
    p.measured_speed = meas[SpeedW-1:0];
    return p;
  endfunction

  // One poll beat; tvalid stays high into the next call unless it idles.
  task automatic send_poll(input poll_t p);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, p};
    do @(posedge clk_i); while (!s_axis_tready_o);
    polls_sent++;
  endtask

  // Stop offering polls and wait for every predicted result.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Write the shadow value of each selected register, lowest index first.
  task automatic apply_cfg(input logic [NumRegs-1:0] sel);
    for (int i = 0; i < NumRegs; i++) begin
      if (sel[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= i[CfgIdxW-1:0];
        cfg_data  <= cfg_shadow[i];
        do @(posedge clk_i); while (!cfg_ready_o);
        cfg_writes++;
      end
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SpeedW-1:0] pick_value(input int unsigned top,
                                                   input int unsigned typical);
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return '0;
    if (r == 1) return SpeedW'(top);
    return SpeedW'($urandom_range(0, typical));
  endfunction

  task automatic random_settings();
    logic [NumRegs-1:0] sel;
    logic [SpeedW-1:0]  margin_v;
    sel = NumRegs'($urandom);
    if (sel[RegMargin]) begin
      margin_v = pick_value(255, 40);
      cfg_shadow[RegMargin] = {8'($urandom), margin_v[MarginW-1:0]};
    end
    if (sel[RegIntegLim])  cfg_shadow[RegIntegLim]  = pick_value(65535, 30);
    if (sel[RegIntegUp])   cfg_shadow[RegIntegUp]   = pick_value(65535, 10);
    if (sel[RegIntegDown]) cfg_shadow[RegIntegDown] = pick_value(65535, 10);
    if (sel[RegReqSpeed]) begin
      // zero most often, so the block picks the max speed and writes it
      case ($urandom_range(0, 5))
        0:       cfg_shadow[RegReqSpeed] = 16'hFFFF;
        1:       cfg_shadow[RegReqSpeed] = SpeedW'(nominal_rpm);
        2:       cfg_shadow[RegReqSpeed] = SpeedW'($urandom);
        default: cfg_shadow[RegReqSpeed] = '0;
      endcase
    end
    for (int i = int'(RegReqSpeed) + 1; i < NumRegs; i++) cfg_shadow[i] = SpeedW'($urandom);
    apply_cfg(sel);
  endtask

  // Result side: random stalls, and a long hold-off when asked.
  initial begin
    int unsigned gap;
    forever begin
      if (holds_done < holds_asked) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        holds_done++;
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        gap = idle_gap();
        if (gap != 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned goal;
    phase = 0;
    cfg_shadow[RegMargin]    = 16'd10;
    cfg_shadow[RegIntegLim]  = 16'd8;
    cfg_shadow[RegIntegUp]   = 16'd2;
    cfg_shadow[RegIntegDown] = 16'd1;
    cfg_shadow[RegReqSpeed]  = 16'd0;
    for (int i = int'(RegReqSpeed) + 1; i < NumRegs; i++) cfg_shadow[i] = 16'hFFFF;

    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // --- directed, register defaults ---
    // info read fails while max speed is still unknown: abort
    send_poll(mk_poll(0, 1, 16'd1000, 0, 0, 0, 16'd1000, 0));
    // max speed latched as zero: no target, configuration fault
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd0, 0));
    // refresh to 1000, exactly on speed
    send_poll(mk_poll(1, 0, 16'd1000, 0, 0, 0, 16'd1000, 0));
    // status read error wins over a fan fault
    send_poll(mk_poll(0, 0, 16'd0, 1, 1, 0, 16'd0, 0));
    // fan fault three polls in a row, hardware on the third
    repeat (3) send_poll(mk_poll(0, 0, 16'd0, 0, 1, 0, 16'd0, 0));
    // speed read error breaks the fault run
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 1, 16'd0, 0));
    // out of margin, speed write of max fails
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd0, 1));
    // out of margin again, write goes through
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'hFFFF, 0));
    // integrator climbs to the limit; error sticks; no write is due, so the write error is ignored
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd2000, 0));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd0, 0));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd0, 1));
    // back in margin: one step down, error still set
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd1050, 0));
    // refresh with a failed info read once max is known: abort
    send_poll(mk_poll(1, 1, 16'hFFFF, 0, 0, 0, 16'd1000, 0));
    // refresh to 65535; commanded speed still rules the target
    send_poll(mk_poll(1, 0, 16'hFFFF, 0, 0, 0, 16'd909, 0));

    // large decrement drains the integrator and clears the error
    settle();
    cfg_shadow[RegIntegDown] = 16'hFFFF;
    apply_cfg(reg_bit(RegIntegDown));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd1000, 0));

    // zero margin: on-speed poll is out of margin; zero limit: no growth
    settle();
    cfg_shadow[RegMargin]   = 16'd0;
    cfg_shadow[RegIntegLim] = 16'd0;
    apply_cfg(reg_bit(RegMargin) | reg_bit(RegIntegLim));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd1000, 0));

    // full-scale step: one poll saturates at the limit
    settle();
    cfg_shadow[RegIntegLim] = 16'hFFFF;
    cfg_shadow[RegIntegUp]  = 16'hFFFF;
    apply_cfg(reg_bit(RegIntegLim) | reg_bit(RegIntegUp));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd1000, 0));

    // limit lowered below the integrator: no growth, error kept
    settle();
    cfg_shadow[RegIntegLim] = 16'd4;
    apply_cfg(reg_bit(RegIntegLim));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd1000, 0));

    // widest margin and no commanded speed: target is max, in margin
    settle();
    cfg_shadow[RegMargin]   = 16'd255;
    cfg_shadow[RegReqSpeed] = 16'd0;
    apply_cfg(reg_bit(RegMargin) | reg_bit(RegReqSpeed));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd0, 0));

    // margin exactly reached: write of max speed
    settle();
    cfg_shadow[RegMargin] = 16'd100;
    apply_cfg(reg_bit(RegMargin));
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'd0, 0));

    // every index once, unused ones included
    settle();
    cfg_shadow[RegReqSpeed] = 16'hFFFF;
    apply_cfg('1);
    send_poll(mk_poll(0, 0, 16'd0, 0, 0, 0, 16'hFFFF, 0));

    // --- random phases ---
    goal = polls_sent + RandomPolls;
    while (polls_sent < goal) begin
      settle();
      case ($urandom_range(0, 7))
        0:       nominal_rpm = $urandom_range(1, 60);
        1:       nominal_rpm = 65535;
        2:       nominal_rpm = 0;
        default: nominal_rpm = $urandom_range(200, 30000);
      endcase
      random_settings();
      idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 60);
      if (phase == 2 || phase == 9) begin
        // long result-side hold with polls still offered
        idle_on = 1'b0;
        holds_asked++;
      end
      repeat (n) send_poll(random_poll());
      phase++;
    end

    settle();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d polls (%0d results checked) over %0d phases and %0d register writes,",
             polls_sent, checked, phase, cfg_writes);
    $display("with random stalls on both sides, two long result hold-offs, %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("** fan_health_monitor: PASSED **");
    end else begin
      $display("** fan_health_monitor: FAILED **");
    end
    $finish;
  end

endmodule
